// File: rtl/vox_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vox_pkg: shared constants of the voxel erode or fill filter
// Sizes, widths, field codes and register indexes.
// ----------------------------------------------------------------------------
package vox_pkg;

  localparam int MAX_ROW_LEN = 128;
  localparam int MAX_ROWS    = 128;
  localparam int MAX_PLANES  = 4096;

  // Row delay memory holds up to one row, plane memory up to one plane.
  localparam int ROW_DEPTH   = MAX_ROW_LEN;
  localparam int PLANE_DEPTH = MAX_ROWS * MAX_ROW_LEN;
  localparam int ROW_AW      = $clog2(ROW_DEPTH);
  localparam int PLANE_AW    = $clog2(PLANE_DEPTH);

  localparam int K_W  = $clog2(MAX_ROW_LEN);
  localparam int J_W  = $clog2(MAX_ROWS);
  localparam int I_W  = $clog2(MAX_PLANES);
  localparam int PL_W = $clog2(PLANE_DEPTH) + 1;

  localparam int VOX_W = 8;
  localparam int ROW_LANES   = 6;
  localparam int PLANE_LANES = 2;

  localparam logic [VOX_W-1:0] FULL_VOXEL = 8'd255;
  localparam logic [4:0]       FILL_LIMIT = 5'd12;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic MODE_ERODE = 1'b0;
  localparam logic MODE_FILL  = 1'b1;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_SIZE_K = 2'd1;
  localparam logic [1:0] REG_SIZE_J = 2'd2;
  localparam logic [1:0] REG_SIZE_I = 2'd3;

endpackage

// File: rtl/voxel_erode_or_fill_3d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_erode_or_fill_3d: streaming 3D binary morphology on byte voxels
// Erodes by the six-neighbourhood or fills holes by an 18-neighbour count.
// ----------------------------------------------------------------------------
// Usage:
// Voxels of one volume enter on the in_ channel in raster order (k fastest,
// then j, then i); in_tuser is 0 for a voxel and 1 for a drain transfer. The
// cleaned volume leaves on the out_ channel in the same order, with out_tlast
// on its final voxel. The result for voxel p is produced by the transfer that
// brings voxel p + size_j*size_k + size_k + 1, so once the volume is complete
// the sender issues drain transfers (one per remaining voxel) to flush the lag.
// Drain transfers sent before the volume is complete are taken and ignored.
// Throughput is one transfer per cycle while in_tready is high: every tap of
// the window is a flop or the registered output of one of two delay memories
// (a row memory and a plane memory), each read and written once per transfer.
// A result is registered in the output queue before it appears on out_tdata.
// A two-entry output queue decouples the sides; in_tready drops only while
// both entries wait on a stalled receiver. The cfg_ channel writes mode, size_k,
// size_j and size_i (indexes 0 to 3) and restarts the volume; it is always
// ready. The user must write it only while idle; the block does not enforce it.
// Reset (rst_n low, synchronous) empties the queue, restarts the volume and
// loads mode 0 and sizes of 128. Memory contents need no clearing.
// ----------------------------------------------------------------------------
module voxel_erode_or_fill_3d (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] voxel_in
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] voxel_out
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int VW = vox_pkg::VOX_W;
  localparam int KW = vox_pkg::K_W;
  localparam int JW = vox_pkg::J_W;
  localparam int IW = vox_pkg::I_W;
  localparam int RAW = vox_pkg::ROW_AW;
  localparam int PAW = vox_pkg::PLANE_AW;
  localparam int PLW = vox_pkg::PL_W;

  // Configuration registers.
  logic        mode_r;
  logic [7:0]  size_k_r;
  logic [7:0]  size_j_r;
  logic [12:0] size_i_r;
  logic        cfg_wr;

  // Clamped sizes.
  logic [7:0]  sk_c;
  logic [7:0]  sj_c;
  logic [12:0] si_c;
  logic [PLW-1:0] pl_c;
  logic [PAW-1:0] lp_m1_r;

  // Position tracking.
  logic [KW-1:0] pk_r, ok_r;
  logic [JW-1:0] pj_r, oj_r;
  logic [IW-1:0] pi_r, oi_r;
  logic started_r, in_done_r;

  // Delay memory pointers.
  logic [RAW-1:0] row_ptr_r, row_rd;
  logic [PAW-1:0] pl_ptr_r, pl_rd;
  logic row_wrap, pl_wrap;

  // Window taps: raw (later positions) and stored (earlier positions).
  logic [VW-1:0] x1_r, ra_r, a1_r, a2_r, rb_r, c1_r, c2_r, cen_r;
  logic [VW-1:0] z1_r, zs0_r, zs1_r, zp0_r, zp1_r;
  logic [VW*vox_pkg::ROW_LANES-1:0]   row_wd, row_rdata;
  logic [VW*vox_pkg::PLANE_LANES-1:0] pl_wd, pl_rdata;
  logic [VW-1:0] r0, r1, r2, r3, r4, r5, p0, p1;

  // Step control.
  logic in_acc, push, at_start, emit, p_last, in_last;
  logic [VW-1:0] raw_in;
  logic interior;
  logic [2:0] face_n;
  logic [4:0] all_n;
  logic [VW-1:0] y, zcur;

  // Output queue.
  logic [1:0]    cnt_r;
  logic [VW-1:0] q0_d_r, q1_d_r;
  logic          q0_l_r, q1_l_r;
  logic          pop, wsel;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= vox_pkg::MODE_ERODE;
      size_k_r <= 8'd128;
      size_j_r <= 8'd128;
      size_i_r <= 13'd128;
    end else if (cfg_wr) begin
      case (cfg_index)
        vox_pkg::REG_MODE:   mode_r   <= cfg_data[0];
        vox_pkg::REG_SIZE_K: size_k_r <= cfg_data[7:0];
        vox_pkg::REG_SIZE_J: size_j_r <= cfg_data[7:0];
        vox_pkg::REG_SIZE_I: size_i_r <= cfg_data;
        default: mode_r <= mode_r;
      endcase
    end
  end

  always_comb begin
    sk_c = (size_k_r < 8'd3) ? 8'd3 :
           (size_k_r > 8'(vox_pkg::MAX_ROW_LEN)) ? 8'(vox_pkg::MAX_ROW_LEN) : size_k_r;
    sj_c = (size_j_r < 8'd3) ? 8'd3 :
           (size_j_r > 8'(vox_pkg::MAX_ROWS)) ? 8'(vox_pkg::MAX_ROWS) : size_j_r;
    si_c = (size_i_r < 13'd3) ? 13'd3 :
           (size_i_r > 13'(vox_pkg::MAX_PLANES)) ? 13'(vox_pkg::MAX_PLANES) : size_i_r;
    pl_c = PLW'(sk_c) * PLW'(sj_c);
  end

  // Plane delay length is plane minus two rows minus one; kept here minus one.
  // It changes only with the sizes and is never compared at pointer zero.
  always_ff @(posedge clk) begin
    lp_m1_r <= PAW'(pl_c - PLW'({sk_c, 1'b0}) - PLW'(2));
  end

  // A transfer steps the window when it brings a voxel of the volume or,
  // once the volume is in, flushes one more pending voxel.
  assign in_acc   = in_tvalid && in_tready;
  assign push     = in_acc && (in_done_r || in_tuser == vox_pkg::OP_DATA);
  assign raw_in   = in_done_r ? '0 : in_tdata;
  assign at_start = (pk_r == KW'(1)) && (pj_r == JW'(1)) && (pi_r == IW'(1)) && !in_done_r;
  assign emit     = push && (started_r || at_start);
  assign in_last  = (pk_r == KW'(sk_c - 8'd1)) && (pj_r == JW'(sj_c - 8'd1)) &&
                    (pi_r == IW'(si_c - 13'd1));
  assign p_last   = (ok_r == KW'(sk_c - 8'd1)) && (oj_r == JW'(sj_c - 8'd1)) &&
                    (oi_r == IW'(si_c - 13'd1));

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr || (emit && p_last)) begin
      pk_r <= '0; pj_r <= '0; pi_r <= '0;
      ok_r <= '0; oj_r <= '0; oi_r <= '0;
      started_r <= 1'b0;
      in_done_r <= 1'b0;
    end else begin
      if (push && !in_done_r) begin
        if (in_last) begin
          in_done_r <= 1'b1;
        end else if (pk_r == KW'(sk_c - 8'd1)) begin
          pk_r <= '0;
          if (pj_r == JW'(sj_c - 8'd1)) begin
            pj_r <= '0;
            pi_r <= pi_r + IW'(1);
          end else begin
            pj_r <= pj_r + JW'(1);
          end
        end else begin
          pk_r <= pk_r + KW'(1);
        end
      end
      if (emit) begin
        started_r <= 1'b1;
        if (ok_r == KW'(sk_c - 8'd1)) begin
          ok_r <= '0;
          if (oj_r == JW'(sj_c - 8'd1)) begin
            oj_r <= '0;
            oi_r <= oi_r + IW'(1);
          end else begin
            oj_r <= oj_r + JW'(1);
          end
        end else begin
          ok_r <= ok_r + KW'(1);
        end
      end
    end
  end

  // Circular pointers: row ring has size_k-1 entries, plane ring lp_m1+1.
  assign row_wrap = (row_ptr_r == RAW'(sk_c - 8'd2));
  assign row_rd   = row_wrap ? '0 : row_ptr_r + RAW'(1);
  assign pl_wrap  = (pl_ptr_r == lp_m1_r);
  assign pl_rd    = pl_wrap ? '0 : pl_ptr_r + PAW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      row_ptr_r <= '0;
      pl_ptr_r  <= '0;
    end else if (push) begin
      row_ptr_r <= row_rd;
      pl_ptr_r  <= pl_rd;
    end
  end

  assign r0 = row_rdata[0*VW +: VW];
  assign r1 = row_rdata[1*VW +: VW];
  assign r2 = row_rdata[2*VW +: VW];
  assign r3 = row_rdata[3*VW +: VW];
  assign r4 = row_rdata[4*VW +: VW];
  assign r5 = row_rdata[5*VW +: VW];
  assign p0 = pl_rdata[0*VW +: VW];
  assign p1 = pl_rdata[1*VW +: VW];

  assign row_wd = {zp1_r, p1, zcur, c1_r, a1_r, raw_in};
  assign pl_wd  = {zs1_r, rb_r};

  vox_ram #(
    .WIDTH(VW * vox_pkg::ROW_LANES),
    .DEPTH(vox_pkg::ROW_DEPTH)
  ) u_row_ram (
    .clk  (clk),
    .we   (push),
    .waddr(row_ptr_r),
    .wdata(row_wd),
    .re   (push),
    .raddr(row_rd),
    .rdata(row_rdata)
  );

  vox_ram #(
    .WIDTH(VW * vox_pkg::PLANE_LANES),
    .DEPTH(vox_pkg::PLANE_DEPTH)
  ) u_plane_ram (
    .clk  (clk),
    .we   (push),
    .waddr(pl_ptr_r),
    .wdata(pl_wd),
    .re   (push),
    .raddr(pl_rd),
    .rdata(pl_rdata)
  );

  always_ff @(posedge clk) begin
    if (push) begin
      x1_r  <= raw_in;
      ra_r  <= r0;
      a1_r  <= ra_r;
      a2_r  <= a1_r;
      rb_r  <= r1;
      c1_r  <= p0;
      c2_r  <= c1_r;
      cen_r <= r2;
      z1_r  <= zcur;
      zs0_r <= r3;
      zs1_r <= zs0_r;
      zp0_r <= r4;
      zp1_r <= zp0_r;
    end
  end

  // Neighbour evaluation. Raw taps: +1 r2, +row c1, +plane a1 and the edge
  // taps; earlier neighbours come from the stored (possibly filled) values.
  always_comb begin
    interior = (ok_r != '0) && (ok_r <= KW'(sk_c - 8'd2)) &&
               (oj_r != '0) && (oj_r <= JW'(sj_c - 8'd2)) &&
               (oi_r != '0) && ({1'b0, oi_r} <= si_c - 13'd2);
    face_n = 3'((r2 != '0)) + 3'((z1_r != '0)) + 3'((c1_r != '0)) +
             3'((zs0_r != '0)) + 3'((a1_r != '0)) + 3'((zp0_r != '0));
    all_n  = 5'(face_n) +
             5'((a2_r != '0)) + 5'((c2_r != '0)) + 5'((zs1_r != '0)) + 5'((zp1_r != '0)) +
             5'((ra_r != '0)) + 5'((p0 != '0)) + 5'((r3 != '0)) + 5'((r4 != '0)) +
             5'((rb_r != '0)) + 5'((r5 != '0)) + 5'((x1_r != '0)) + 5'((p1 != '0));
    if (mode_r == vox_pkg::MODE_ERODE) begin
      y    = (interior && cen_r != '0 && face_n == 3'd6) ? vox_pkg::FULL_VOXEL : '0;
      zcur = cen_r;
    end else begin
      if (interior && cen_r == '0 && face_n != 3'd0 && all_n > vox_pkg::FILL_LIMIT) begin
        y = vox_pkg::FULL_VOXEL;
      end else begin
        y = cen_r;
      end
      zcur = y;
    end
  end

  // Two-entry output queue.
  assign pop  = out_tvalid && out_tready;
  assign wsel = (cnt_r == 2'd2) || (cnt_r == 2'd1 && !pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r - 2'(pop) + 2'(emit);
    end
  end

  // A new result goes to the head when the queue is empty or its only entry
  // leaves in the same cycle, else to the second entry, which a pop moves up.
  always_ff @(posedge clk) begin
    if (emit && !wsel) begin
      q0_d_r <= y;
      q0_l_r <= p_last;
    end else if (pop) begin
      q0_d_r <= q1_d_r;
      q0_l_r <= q1_l_r;
    end
    if (emit && wsel) begin
      q1_d_r <= y;
      q1_l_r <= p_last;
    end
  end

  assign in_tready  = (cnt_r != 2'd2);
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = q0_d_r;
  assign out_tlast  = q0_l_r;

  // Checks.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("output queue overflow");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (row_ptr_r == '0 && pl_ptr_r == '0 && !started_r))
    else $error("config write did not restart the volume");

  a_row_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    row_ptr_r <= RAW'(sk_c - 8'd2)) else $error("row pointer out of ring");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && p_last) |=> (!started_r && !in_done_r))
    else $error("volume not restarted after its last voxel");

endmodule

// File: rtl/vox_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vox_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vox_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
